### design/histogram_inverse_cdf_sampler_core_defines.svh
// Assertion macros for the histogram inverse-CDF sampler.
// Included by the modules that carry assertions; no other dependencies.
`ifndef HISTOGRAM_INVERSE_CDF_SAMPLER_CORE_DEFINES_SVH
`define HISTOGRAM_INVERSE_CDF_SAMPLER_CORE_DEFINES_SVH

`ifndef SYNTH
`define HICS_ASSERT_IMPLY(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("hics: assertion failed");
`define HICS_ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("hics: assertion failed");
`else
`define HICS_ASSERT_IMPLY(lbl, clk, rst_n, cond, expr)
`define HICS_ASSERT_NEXT(lbl, clk, rst_n, cond, expr)
`endif

`endif

### design/hics_pkg.sv
// Shared types and constants for the histogram inverse-CDF sampler.
// No dependencies.
package hics_pkg;

    localparam int DEF_MAX_BINS     = 1024;
    localparam int DEF_WEIGHT_BITS  = 32;
    localparam int WEIGHT_PORT_BITS = 32;
    localparam int FRAC_BITS        = 32;
    localparam int OUT_BITS         = 10;
    localparam int CFG_BITS         = 4;
    localparam int IDX_EXT_BITS     = 16;

    typedef enum logic [1:0] {
        FN_CLEAR  = 2'd0,
        FN_APPEND = 2'd1,
        FN_DRAW   = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ADD,
        ST_RD,
        ST_CMP,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic op_clear;
        logic op_append;
        logic ld_frac;
        logic mul_lo;
        logic mul_hi;
        logic add_init;
        logic rd_mid;
        logic rd_lo;
        logic cmp_step;
        logic fin;
        logic emit_err;
        logic searching;
    } t_ctl;

    typedef struct packed {
        logic empty;
        logic more;
    } t_sts;

endpackage

### design/hics_ram.sv
// Cumulative-start table: one write port, one registered read port.
// Depends on nothing.
module hics_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 42
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/hics_ctrl.sv
// Draw sequencer: scaling multiply steps, then binary-search read/compare steps.
// Depends on hics_pkg.
module hics_ctrl
    import hics_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_func,
    input  t_sts       i_sts,
    output t_ctl       o_ctl,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && t_func'(i_func) == FN_DRAW && !i_sts.empty) begin
                    n_state = ST_MUL_LO;
                end
            end
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_ADD;
            ST_ADD:    n_state = ST_RD;
            ST_RD: begin
                if (i_sts.more) begin
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_CMP:    n_state = ST_RD;
            ST_FIN:    n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    case (t_func'(i_func))
                        FN_CLEAR:  o_ctl.op_clear  = 1'b1;
                        FN_APPEND: o_ctl.op_append = 1'b1;
                        FN_DRAW: begin
                            o_ctl.emit_err = i_sts.empty;
                            o_ctl.ld_frac  = !i_sts.empty;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL_LO: o_ctl.mul_lo = 1'b1;
            ST_MUL_HI: o_ctl.mul_hi = 1'b1;
            ST_ADD:    o_ctl.add_init = 1'b1;
            ST_RD: begin
                o_ctl.searching = 1'b1;
                o_ctl.rd_mid    = i_sts.more;
                o_ctl.rd_lo     = !i_sts.more;
            end
            ST_CMP: begin
                o_ctl.searching = 1'b1;
                o_ctl.cmp_step  = 1'b1;
            end
            ST_FIN:    o_ctl.fin = 1'b1;
            default:   o_ctl = '0;
        endcase
    end

endmodule

### design/hics_dp.sv
// Datapath: table fill, running total, shared 32x32 multiplier and comparator,
// search bounds and result registers. Depends on hics_pkg, hics_ram, defines header.
`include "histogram_inverse_cdf_sampler_core_defines.svh"

module hics_dp
    import hics_pkg::*;
#(
    parameter int MAX_BINS    = DEF_MAX_BINS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_ctl                        i_ctl,
    input  logic [WEIGHT_PORT_BITS-1:0] i_weight,
    input  logic [FRAC_BITS-1:0]        i_random_fraction,
    input  logic [CFG_BITS-1:0]         i_column_bits,
    output t_sts                        o_sts,
    output logic                        o_valid,
    output logic [OUT_BITS-1:0]         o_bin_index,
    output logic [OUT_BITS-1:0]         o_row,
    output logic [OUT_BITS-1:0]         o_column,
    output logic                        o_status
);

    localparam int IDX_BITS = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_BITS = $clog2(MAX_BINS + 1);
    localparam int SUM_BITS = WEIGHT_BITS + IDX_BITS;
    localparam logic [WEIGHT_PORT_BITS-1:0] W_MASK = (WEIGHT_BITS >= WEIGHT_PORT_BITS) ?
        {WEIGHT_PORT_BITS{1'b1}} :
        WEIGHT_PORT_BITS'((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(MAX_BINS);

    logic [CNT_BITS-1:0]    r_count;
    logic [SUM_BITS-1:0]    r_total;
    logic [FRAC_BITS-1:0]   r_frac;
    logic [63:0]            r_prod;
    logic [SUM_BITS-1:0]    r_t;
    logic [CNT_BITS-1:0]    r_lo;
    logic [CNT_BITS-1:0]    r_hi;
    logic [CNT_BITS-1:0]    r_mid;
    logic                   r_valid;
    logic                   r_status;
    logic [OUT_BITS-1:0]    r_bin;
    logic [OUT_BITS-1:0]    r_row;
    logic [OUT_BITS-1:0]    r_col;

    logic [63:0]            total64;
    logic [31:0]            mul_a;
    logic [63:0]            mul_p;
    logic [CNT_BITS-1:0]    mid;
    logic                   can_append;
    logic                   we;
    logic [IDX_BITS-1:0]    raddr;
    logic [SUM_BITS-1:0]    rdata;
    logic                   is_below;
    logic                   is_equal;
    logic [CNT_BITS-1:0]    pick;
    logic [IDX_EXT_BITS-1:0] idx_ext;
    logic [IDX_EXT_BITS-1:0] col_mask;

    function automatic logic [IDX_BITS-1:0] r_mid_next_addr(input logic [CNT_BITS-1:0] a);
        return a[IDX_BITS-1:0];
    endfunction

    // shared multiplier: total split into 32-bit halves
    assign total64 = 64'(r_total);
    assign mul_a   = i_ctl.mul_hi ? total64[63:32] : total64[31:0];
    assign mul_p   = 64'(mul_a) * 64'(r_frac);

    assign mid        = r_lo + ((r_hi - r_lo) >> 1);
    assign can_append = r_count < CNT_FULL;
    assign we         = i_ctl.op_append && can_append;
    assign raddr      = i_ctl.rd_lo ? r_mid_next_addr(r_lo) : r_mid_next_addr(mid);

    hics_ram #(
        .DEPTH (MAX_BINS),
        .AW    (IDX_BITS),
        .DW    (SUM_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[IDX_BITS-1:0]),
        .i_wdata (r_total),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // shared comparator
    assign is_below = rdata < r_t;
    assign is_equal = rdata == r_t;

    always_comb begin
        if (r_lo < r_count && is_equal) begin
            pick = r_lo;
        end else if (r_lo == '0) begin
            pick = '0;
        end else begin
            pick = r_lo - CNT_BITS'(1);
        end
    end

    assign idx_ext  = IDX_EXT_BITS'(pick[IDX_BITS-1:0]);
    assign col_mask = ~({IDX_EXT_BITS{1'b1}} << i_column_bits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.fin || i_ctl.emit_err;
            if (i_ctl.op_clear) begin
                r_count <= '0;
                r_total <= '0;
            end else if (we) begin
                r_count <= r_count + CNT_BITS'(1);
                r_total <= r_total + SUM_BITS'(i_weight & W_MASK);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_frac) begin
            r_frac <= i_random_fraction;
        end
        if (i_ctl.mul_lo || i_ctl.mul_hi) begin
            r_prod <= mul_p;
        end
        if (i_ctl.mul_hi) begin
            r_t <= SUM_BITS'(r_prod >> 32);
        end else if (i_ctl.add_init) begin
            r_t <= r_t + SUM_BITS'(r_prod);
        end
        if (i_ctl.add_init) begin
            r_lo <= '0;
            r_hi <= r_count;
        end else if (i_ctl.cmp_step) begin
            if (is_below) begin
                r_lo <= r_mid + CNT_BITS'(1);
            end else begin
                r_hi <= r_mid;
            end
        end
        if (i_ctl.rd_mid) begin
            r_mid <= mid;
        end
        if (i_ctl.emit_err) begin
            r_status <= 1'b1;
            r_bin    <= '0;
            r_row    <= '0;
            r_col    <= '0;
        end else if (i_ctl.fin) begin
            r_status <= 1'b0;
            r_bin    <= OUT_BITS'(idx_ext);
            r_row    <= OUT_BITS'(idx_ext >> i_column_bits);
            r_col    <= OUT_BITS'(idx_ext & col_mask);
        end
    end

    assign o_sts.empty = (r_count == '0) || (r_total == '0);
    assign o_sts.more  = r_lo < r_hi;
    assign o_valid     = r_valid;
    assign o_bin_index = r_bin;
    assign o_row       = r_row;
    assign o_column    = r_col;
    assign o_status    = r_status;

    `HICS_ASSERT_IMPLY(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL)
    `HICS_ASSERT_IMPLY(a_bounds, i_clk, i_rst_n, i_ctl.searching, r_lo <= r_hi && r_hi <= r_count)
    `HICS_ASSERT_NEXT(a_fin_emit, i_clk, i_rst_n, i_ctl.fin, r_valid && !r_status)

endmodule

### design/histogram_inverse_cdf_sampler_core.sv
// Top level of the histogram inverse-CDF sampler: config register, sequencer, datapath.
// Depends on hics_pkg, hics_ctrl, hics_dp (and hics_ram below it).
//
// channel  | handshake                 | payload
// ---------+---------------------------+-----------------------------------------------
// item in  | start, busy               | i_func, i_weight, i_random_fraction
// config   | i_cfg_valid, o_cfg_ready  | i_cfg_data (column_bits)
// result   | o_valid (one-cycle strobe)| o_bin_index, o_row, o_column, o_status
//
// Clear and append are taken in idle; busy stays low. An append beyond capacity is dropped.
// A draw keeps busy high through the multiply, add and binary-search read/compare states
// (at most log2(MAX_BINS)+1 search steps) and FIN; the result follows FIN.
// A draw on an empty or zero-total table gives its error result the cycle after acceptance.
// Reset (i_rst_n low, synchronous) empties the table and zeroes column_bits.
// Results cannot be stalled by the receiver.
module histogram_inverse_cdf_sampler_core
    import hics_pkg::*;
#(
    parameter int MAX_BINS    = DEF_MAX_BINS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_func,
    input  logic [WEIGHT_PORT_BITS-1:0] i_weight,
    input  logic [FRAC_BITS-1:0]        i_random_fraction,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_BITS-1:0]         i_cfg_data,
    output logic                        o_valid,
    output logic [OUT_BITS-1:0]         o_bin_index,
    output logic [OUT_BITS-1:0]         o_row,
    output logic [OUT_BITS-1:0]         o_column,
    output logic                        o_status
);

    logic [CFG_BITS-1:0] r_column_bits;
    t_ctl                ctl;
    t_sts                sts;
    logic                busy_int;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_bits <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_column_bits <= i_cfg_data;
        end
    end

    assign o_cfg_ready = !busy_int;
    assign busy        = busy_int;

    hics_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy_int)
    );

    hics_dp #(
        .MAX_BINS    (MAX_BINS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .i_weight          (i_weight),
        .i_random_fraction (i_random_fraction),
        .i_column_bits     (r_column_bits),
        .o_sts             (sts),
        .o_valid           (o_valid),
        .o_bin_index       (o_bin_index),
        .o_row             (o_row),
        .o_column          (o_column),
        .o_status          (o_status)
    );

endmodule
